// ----- rtl/dss_pkg.sv -----
// Shared types, constants and segment table for the decimal seven-segment serializer.
`default_nettype none
package dss_pkg;

  localparam int unsigned DefMaxDigits = 8;

  // Reciprocal of ten for 16-bit operands: q = (v * DivMagic) >> DivShift
  localparam logic [15:0] DivMagic = 16'hCCCD;
  localparam int unsigned DivShift = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LATCH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new input transfer
    logic shift;      // a serial bit transfer completed
    logic show_bits;  // output carries real shifted bits
  } dss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_zero;    // incoming digit count is zero
    logic bit_last;   // current bit is the last of its byte
    logic digit_last; // current byte is the last digit
  } dss_status_t;

  // Active-low segment code, bits dp,g,f,e,d,c,b,a
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0: code = 8'hC0;
      4'd1: code = 8'hF9;
      4'd2: code = 8'hA4;
      4'd3: code = 8'hB0;
      4'd4: code = 8'h99;
      4'd5: code = 8'h92;
      4'd6: code = 8'h82;
      4'd7: code = 8'hF8;
      4'd8: code = 8'h80;
      4'd9: code = 8'h98;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dss_ctrl.sv -----
// Controller state machine for the decimal seven-segment serializer.
`default_nettype none
module dss_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire dss_pkg::dss_status_t status_i,
  output dss_pkg::dss_cmd_t         cmd_o
);
  import dss_pkg::*;

  state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_zero ? ST_LATCH : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!out_stall_i && status_i.bit_last && status_i.digit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_LATCH: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.shift     = 1'b0;
    cmd_o.show_bits = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_SHIFT: begin
        out_valid_o     = 1'b1;
        cmd_o.show_bits = 1'b1;
        cmd_o.shift     = !out_stall_i;
      end
      ST_LATCH: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/dss_datapath.sv -----
// Datapath: divide-by-ten digit extraction, segment shift register and counters.
`default_nettype none
module dss_datapath #(
  parameter int unsigned MaxDigits = dss_pkg::DefMaxDigits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       value_i,
  input  wire logic [3:0]        digit_count_i,
  input  wire logic              display_select_i,
  input  wire dss_pkg::dss_cmd_t cmd_i,
  output dss_pkg::dss_status_t   status_o,
  output logic                   display_id_o,
  output logic                   serial_bit_o,
  output logic                   bit_valid_o,
  output logic                   latch_pulse_o
);
  import dss_pkg::*;

  localparam int unsigned CntW = $clog2(MaxDigits + 1);
  localparam logic [3:0]  MaxCnt4 = 4'(MaxDigits);

  logic [15:0]     value_q, value_d;
  logic [7:0]      seg_q, seg_d;
  logic            id_q, id_d;
  logic [2:0]      bit_q, bit_d;
  logic [CntW-1:0] left_q, left_d;

  logic [15:0]     div_in;
  logic [31:0]     prod;
  logic [15:0]     quot;
  logic [15:0]     rem;
  logic [CntW-1:0] count_sat;

  // Divide by ten through the reciprocal, remainder by subtraction
  assign div_in = cmd_i.load ? value_i : value_q;
  assign prod   = {16'b0, div_in} * {16'b0, DivMagic};
  assign quot   = 16'(prod[31:DivShift]);
  assign rem    = div_in - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0});

  // Clamp the digit count
  assign count_sat = (digit_count_i > MaxCnt4) ? CntW'(MaxDigits) : CntW'(digit_count_i);

  assign status_o.in_zero    = (digit_count_i == 4'd0);
  assign status_o.bit_last   = (bit_q == 3'd7);
  assign status_o.digit_last = (left_q == CntW'(1));

  // Load a transfer, advance bits, fetch the next digit at a byte end
  always_comb begin
    value_d = value_q;
    seg_d   = seg_q;
    id_d    = id_q;
    bit_d   = bit_q;
    left_d  = left_q;
    priority if (cmd_i.load) begin
      value_d = quot;
      seg_d   = seg_code(rem[3:0]);
      id_d    = display_select_i;
      bit_d   = 3'd0;
      left_d  = count_sat;
    end else if (cmd_i.shift) begin
      bit_d = bit_q + 3'd1;
      if (status_o.bit_last) begin
        left_d  = left_q - CntW'(1);
        value_d = quot;
        seg_d   = seg_code(rem[3:0]);
      end else begin
        seg_d = {seg_q[6:0], 1'b0};
      end
    end else begin
      // hold everything
      bit_d = bit_q;
    end
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= 3'd0;
      left_q <= '0;
    end else begin
      bit_q  <= bit_d;
      left_q <= left_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    seg_q   <= seg_d;
    id_q    <= id_d;
  end

  // Drive the result fields
  assign display_id_o  = id_q;
  assign serial_bit_o  = cmd_i.show_bits & seg_q[7];
  assign bit_valid_o   = cmd_i.show_bits;
  assign latch_pulse_o = cmd_i.show_bits ? (status_o.bit_last & status_o.digit_last) : 1'b1;

endmodule
`default_nettype wire

// ----- rtl/decimal_seven_segment_serializer.sv -----
// Top level of the decimal seven-segment serializer.
//
// Input channel (in_valid_i / in_stall_o) carries a 16-bit value, a digit
// count and a display select. A transfer is taken only while the block is
// idle. The block then sends the value's decimal digits, least significant
// first, as active-low segment bytes, MSB first, one output transfer per bit
// on out_valid_o / out_stall_i. latch_pulse_o marks the final transfer.
// Digit counts above MAX_DIGITS are clamped. A count of zero yields a single
// transfer with bit_valid_o low and latch_pulse_o high.
// Latency: the first bit is offered in the cycle after the input transfer.
// Each number takes count*8 output transfers (one for a zero count), and
// the next input is taken only after a return to idle; the bit shifter
// emits one bit per cycle unless stalled, and the divide-by-ten unit makes the
// next digit in the same cycle as the last bit of a byte.
// A stall from the receiver freezes the current bit and all counters.
// Reset returns the controller to idle with no output pending.
`default_nettype none
module decimal_seven_segment_serializer #(
  parameter int unsigned MAX_DIGITS = dss_pkg::DefMaxDigits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] value_i,
  input  wire logic [3:0]  digit_count_i,
  input  wire logic        display_select_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             display_id_o,
  output logic             serial_bit_o,
  output logic             bit_valid_o,
  output logic             latch_pulse_o
);
  import dss_pkg::*;

  dss_cmd_t    cmd;
  dss_status_t status;

  // Sequence the transfers
  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Digits, segments and serial bits
  dss_datapath #(
    .MaxDigits (MAX_DIGITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .value_i          (value_i),
    .digit_count_i    (digit_count_i),
    .display_select_i (display_select_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .display_id_o     (display_id_o),
    .serial_bit_o     (serial_bit_o),
    .bit_valid_o      (bit_valid_o),
    .latch_pulse_o    (latch_pulse_o)
  );

`ifndef ASSERT_OFF
  // A completed latch transfer ends the number
  a_latch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && latch_pulse_o |=> !in_stall_o && !out_valid_o)
    else $error("latch transfer did not return to idle");

  // A result without a real bit is only the latch strobe
  a_empty_is_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bit_valid_o |-> latch_pulse_o)
    else $error("non-bit result without latch");

  // An accepted input is followed by a result
  a_accept_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result after input transfer");

  // A zero digit count gives the latch alone
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && digit_count_i == 4'd0 |=> !bit_valid_o && latch_pulse_o)
    else $error("zero count did not give a lone latch");
`endif

endmodule
`default_nettype wire
